[rtl/ado_pkg.sv]
// Shared types, register codes and constants of the Adam update unit.
// No dependencies; every other file refers to it by scoped names.
package ado_pkg;

    localparam int NUM_ELEMENTS = 4096;
    localparam int ADDR_W       = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_STRENGTH  = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_L1   = 2'd1;
    localparam logic [1:0] MODE_L2   = 2'd2;
    localparam logic [1:0] MODE_UNK  = 2'd3;

    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    localparam logic [24:0] ONE_Q24  = 25'd16777216;
    localparam logic [63:0] EPS_Q40  = 64'd10995;
    localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;
    localparam logic [32:0] STEP_MAX = 33'h1_0000_0000;

    localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
    localparam logic [23:0] RST_DECAY_SECOND  = 24'd16760438;
    localparam logic [23:0] RST_DECAY_FIRST   = 24'd15099494;

    // Result bits resolved per stage in each iterative unit
    localparam int VD_STEPS  = 2;
    localparam int VD_STAGES = 64 / VD_STEPS;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = 32 / SQ_STEPS;
    localparam int SD_STEPS  = 2;
    localparam int SD_STAGES = 34 / SD_STEPS;

    typedef struct packed {
        logic [23:0] lr;
        logic [23:0] d2;
        logic [23:0] d1;
        logic [1:0]  mode;
        logic [23:0] strength;
    } t_cfg;

    // Per-item side band carried alongside the arithmetic
    typedef struct packed {
        logic               upd;
        logic signed [31:0] w;
        logic               neg;
        logic [55:0]        num;
        logic [24:0]        q1;
        logic               status;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

[rtl/ado_moment_unit.sv]
// Moment memories with read-modify-write, L2 decay, decay powers and clearing pass.
// Depends on ado_pkg.
module ado_moment_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_acc,
    input  ado_pkg::t_cfg       i_cfg,
    input  logic                i_kind,
    input  logic [11:0]         i_idx,
    input  logic signed [31:0]  i_w,
    input  logic signed [31:0]  i_g,
    output logic                o_clearing,
    output logic                o_valid,
    output logic [47:0]         o_v,
    output logic [24:0]         o_q2,
    output ado_pkg::t_side      o_side
);

    localparam int AW = ado_pkg::ADDR_W;

    function automatic logic [24:0] comp_q(input logic [24:0] p);
        logic [24:0] q;
        q = (p >= ado_pkg::ONE_Q24) ? 25'd0 : 25'(ado_pkg::ONE_Q24 - p);
        return (q == 25'd0) ? 25'd1 : q;
    endfunction

    logic signed [31:0] mem_m [0:ado_pkg::NUM_ELEMENTS-1];
    logic [47:0]        mem_v [0:ado_pkg::NUM_ELEMENTS-1];

    logic          r_clr;
    logic [AW-1:0] r_clr_addr;
    logic [24:0]   r_pf, r_ps;

    // stage 1
    logic               r1_valid, r1_kind;
    logic [11:0]        r1_idx;
    logic signed [31:0] r1_w, r1_g;
    // stage 2
    logic               r2_valid, r2_upd, r2_status;
    logic [11:0]        r2_idx;
    logic signed [31:0] r2_w, r2_g, r2_m_rd;
    logic [24:0]        r2_q1, r2_q2;
    // stage 3
    logic               r3_valid, r3_upd, r3_status;
    logic [11:0]        r3_idx;
    logic signed [31:0] r3_w, r3_m;
    logic [47:0]        r3_gsq, r3_v_rd;
    logic [24:0]        r3_q1, r3_q2;
    // stage 4
    logic               r4_valid;
    logic [47:0]        r4_v;
    logic [24:0]        r4_q2;
    ado_pkg::t_side     r4_side;
    // last writes, for forwarding
    logic               r_mf_valid, r_vf_valid;
    logic [11:0]        r_mf_idx, r_vf_idx;
    logic signed [31:0] r_mf_val;
    logic [47:0]        r_vf_val;

    // ---- stage 1: regularisation and classification
    logic signed [24:0] w_str;
    logic signed [56:0] w_l2_prod;
    logic signed [33:0] w_g_sum;
    logic signed [31:0] w_g_l2, w_g1;
    logic               w_rej, w_in_range, w_upd, w_status;
    logic [48:0]        w_pf_prod, w_ps_prod;

    assign w_str      = signed'({1'b0, i_cfg.strength});
    assign w_l2_prod  = w_str * r1_w;
    assign w_g_sum    = 34'(r1_g) + 34'(w_l2_prod >>> 23);
    assign w_g_l2     = ado_pkg::sat32(64'(w_g_sum));
    assign w_in_range = 32'(r1_idx) < 32'(ado_pkg::NUM_ELEMENTS);

    always_comb begin
        w_g1 = r1_g;
        unique case (i_cfg.mode) inside
            ado_pkg::MODE_L1, ado_pkg::MODE_UNK: begin
                w_rej = 1'b1;
            end
            ado_pkg::MODE_L2: begin
                w_rej = 1'b0;
                w_g1  = w_g_l2;
            end
            default: begin
                w_rej = 1'b0;
            end
        endcase
    end

    assign w_status  = (r1_kind == ado_pkg::KIND_ELEM) && w_rej;
    assign w_upd     = (r1_kind == ado_pkg::KIND_ELEM) && !w_rej && w_in_range;
    assign w_pf_prod = r_pf * i_cfg.d1;
    assign w_ps_prod = r_ps * i_cfg.d2;

    // ---- stage 2: first moment
    logic signed [31:0] w_m_old, w_m_new;
    logic signed [24:0] w_d1s;
    logic signed [25:0] w_c1;
    logic signed [56:0] w_p1;
    logic signed [57:0] w_p2;
    logic signed [58:0] w_m_sum;
    logic [31:0]        w_g_mag;
    logic [63:0]        w_g_sq;

    assign w_m_old = (r_mf_valid && r_mf_idx == r2_idx) ? r_mf_val : r2_m_rd;
    assign w_d1s   = signed'({1'b0, i_cfg.d1});
    assign w_c1    = signed'(26'(ado_pkg::ONE_Q24) - 26'(i_cfg.d1));
    assign w_p1    = w_d1s * w_m_old;
    assign w_p2    = w_c1 * r2_g;
    assign w_m_sum = 59'(w_p1) + 59'(w_p2);
    assign w_m_new = ado_pkg::sat32(64'(w_m_sum >>> 24));
    assign w_g_mag = r2_g[31] ? (~r2_g + 32'd1) : r2_g;
    assign w_g_sq  = w_g_mag * w_g_mag;

    // ---- stage 3: second moment and step numerator
    logic [47:0] w_v_old, w_v_new;
    logic [24:0] w_c2;
    logic [49:0] w_hi, w_lo;
    logic [50:0] w_v_sum;
    logic [31:0] w_m_mag;
    logic [55:0] w_num;

    assign w_v_old = (r_vf_valid && r_vf_idx == r3_idx) ? r_vf_val : r3_v_rd;
    assign w_c2    = 25'(ado_pkg::ONE_Q24 - 25'(i_cfg.d2));
    assign w_hi    = 50'(i_cfg.d2 * w_v_old[47:24]) + 50'(w_c2 * r3_gsq[47:24]);
    assign w_lo    = 50'(i_cfg.d2 * w_v_old[23:0]) + 50'(w_c2 * r3_gsq[23:0]);
    assign w_v_sum = 51'(w_hi) + 51'(w_lo[49:24]);
    assign w_v_new = (w_v_sum > 51'(ado_pkg::MAX48)) ? ado_pkg::MAX48 : w_v_sum[47:0];
    assign w_m_mag = r3_m[31] ? (~r3_m + 32'd1) : r3_m;
    assign w_num   = i_cfg.lr * w_m_mag;

    // ---- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_pf       <= ado_pkg::ONE_Q24;
            r_ps       <= ado_pkg::ONE_Q24;
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r4_valid   <= 1'b0;
            r_mf_valid <= 1'b0;
            r_vf_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ado_pkg::NUM_ELEMENTS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (i_en) begin
                r1_valid   <= i_acc;
                r2_valid   <= r1_valid;
                r3_valid   <= r2_valid;
                r4_valid   <= r3_valid;
                r_mf_valid <= r2_valid && r2_upd;
                r_vf_valid <= r3_valid && r3_upd;
                // advance the decay powers on a new training step
                if (r1_valid && r1_kind == ado_pkg::KIND_STEP) begin
                    r_pf <= w_pf_prod[48:24];
                    r_ps <= w_ps_prod[48:24];
                end
            end
        end
    end

    // ---- memories
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem_m[r_clr_addr] <= '0;
            mem_v[r_clr_addr] <= '0;
        end else if (i_en) begin
            if (r2_valid && r2_upd) begin
                mem_m[AW'(r2_idx)] <= w_m_new;
            end
            if (r3_valid && r3_upd) begin
                mem_v[AW'(r3_idx)] <= w_v_new;
            end
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r1_kind <= i_kind;
            r1_idx  <= i_idx;
            r1_w    <= i_w;
            r1_g    <= i_g;
        end
        if (i_en) begin
            r2_m_rd   <= mem_m[AW'(r1_idx)];
            r2_upd    <= w_upd;
            r2_status <= w_status;
            r2_idx    <= r1_idx;
            r2_w      <= r1_w;
            r2_g      <= w_g1;
            r2_q1     <= comp_q(r_pf);
            r2_q2     <= comp_q(r_ps);

            r3_v_rd   <= mem_v[AW'(r2_idx)];
            r3_upd    <= r2_upd;
            r3_status <= r2_status;
            r3_idx    <= r2_idx;
            r3_w      <= r2_w;
            r3_m      <= w_m_new;
            r3_gsq    <= w_g_sq[63:16];
            r3_q1     <= r2_q1;
            r3_q2     <= r2_q2;

            r4_v           <= w_v_new;
            r4_q2          <= r3_q2;
            r4_side.upd    <= r3_upd;
            r4_side.w      <= r3_w;
            r4_side.neg    <= r3_m[31];
            r4_side.num    <= w_num;
            r4_side.q1     <= r3_q1;
            r4_side.status <= r3_status;

            r_mf_idx <= r2_idx;
            r_mf_val <= w_m_new;
            r_vf_idx <= r3_idx;
            r_vf_val <= w_v_new;
        end
    end

    assign o_clearing = r_clr;
    assign o_valid    = r4_valid;
    assign o_v        = r4_v;
    assign o_q2       = r4_q2;
    assign o_side     = r4_side;

`ifndef SYNTHESIS
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !(r1_valid || r2_valid || r3_valid || r4_valid))
        else $error("pipeline holds an item during the clearing pass");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pf <= ado_pkg::ONE_Q24) && (r_ps <= ado_pkg::ONE_Q24))
        else $error("decay power above one");

    a_fwd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_mf_valid) && $stable(r_vf_valid) && $stable(r2_m_rd))
        else $error("forwarding state changed while stalled");
`endif

endmodule

[rtl/ado_vdiv.sv]
// Pipelined restoring divider: bias-corrected second moment v * 2^32 / q2 plus epsilon.
// Depends on ado_pkg.
module ado_vdiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [47:0]    i_v,
    input  logic [24:0]    i_q2,
    input  ado_pkg::t_side i_side,
    output logic           o_valid,
    output logic [63:0]    o_x,
    output ado_pkg::t_side o_side
);

    localparam int N = ado_pkg::VD_STAGES;

    logic [N:0]     r_valid;
    logic [24:0]    r_rem  [0:N];
    logic [63:0]    r_dvd  [0:N];
    logic [63:0]    r_quo  [0:N];
    logic [24:0]    r_q2   [0:N];
    logic           r_ovf  [0:N];
    ado_pkg::t_side r_side [0:N];

    logic [24:0] n_rem [1:N];
    logic [63:0] n_dvd [1:N];
    logic [63:0] n_quo [1:N];

    always_comb begin : div_steps
        logic [25:0] t;
        logic [24:0] rem;
        logic [63:0] dvd;
        logic [63:0] quo;
        for (int s = 0; s < N; s++) begin
            rem = r_rem[s];
            dvd = r_dvd[s];
            quo = r_quo[s];
            for (int j = 0; j < ado_pkg::VD_STEPS; j++) begin
                t   = {rem, dvd[63]};
                dvd = {dvd[62:0], 1'b0};
                if (t >= {1'b0, r_q2[s]}) begin
                    rem = 25'(t - {1'b0, r_q2[s]});
                    quo = {quo[62:0], 1'b1};
                end else begin
                    rem = t[24:0];
                    quo = {quo[62:0], 1'b0};
                end
            end
            n_rem[s+1] = rem;
            n_dvd[s+1] = dvd;
            n_quo[s+1] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // integer part of v / q2 must stay below 2^32, else saturate
            r_rem[0]  <= {9'd0, i_v[47:32]};
            r_dvd[0]  <= {i_v[31:0], 32'd0};
            r_quo[0]  <= '0;
            r_q2[0]   <= i_q2;
            r_ovf[0]  <= ({9'd0, i_v[47:32]} >= i_q2);
            r_side[0] <= i_side;
            for (int s = 0; s < N; s++) begin
                r_rem[s+1]  <= n_rem[s+1];
                r_dvd[s+1]  <= n_dvd[s+1];
                r_quo[s+1]  <= n_quo[s+1];
                r_q2[s+1]   <= r_q2[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    logic [63:0] w_pre;
    assign w_pre   = r_ovf[N] ? '1 : r_quo[N];
    assign o_x     = (w_pre > (64'hFFFF_FFFF_FFFF_FFFF - ado_pkg::EPS_Q40)) ? '1
                     : w_pre + ado_pkg::EPS_Q40;
    assign o_valid = r_valid[N];
    assign o_side  = r_side[N];

endmodule

[rtl/ado_sqrt.sv]
// Pipelined digit-by-digit integer square root of a 64-bit radicand.
// Depends on ado_pkg.
module ado_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_x,
    input  ado_pkg::t_side i_side,
    output logic           o_valid,
    output logic [31:0]    o_s,
    output ado_pkg::t_side o_side
);

    localparam int N = ado_pkg::SQ_STAGES;

    logic [N:0]     r_valid;
    logic [63:0]    r_rad  [0:N];
    logic [33:0]    r_rem  [0:N];
    logic [31:0]    r_root [0:N];
    ado_pkg::t_side r_side [0:N];

    logic [63:0] n_rad  [1:N];
    logic [33:0] n_rem  [1:N];
    logic [31:0] n_root [1:N];

    always_comb begin : root_steps
        logic [35:0] t;
        logic [35:0] trial;
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
        for (int s = 0; s < N; s++) begin
            rad  = r_rad[s];
            rem  = r_rem[s];
            root = r_root[s];
            for (int j = 0; j < ado_pkg::SQ_STEPS; j++) begin
                t     = {rem, rad[63:62]};
                trial = {2'b00, root, 2'b01};
                rad   = {rad[61:0], 2'b00};
                if (t >= trial) begin
                    rem  = 34'(t - trial);
                    root = {root[30:0], 1'b1};
                end else begin
                    rem  = t[33:0];
                    root = {root[30:0], 1'b0};
                end
            end
            n_rad[s+1]  = rad;
            n_rem[s+1]  = rem;
            n_root[s+1] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_x;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int s = 0; s < N; s++) begin
                r_rad[s+1]  <= n_rad[s+1];
                r_rem[s+1]  <= n_rem[s+1];
                r_root[s+1] <= n_root[s+1];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_valid[N];
    assign o_s     = r_root[N];
    assign o_side  = r_side[N];

endmodule

[rtl/ado_sdiv.sv]
// Step size: lr * |m| * 2^20 / (q1 * s), capped at 2^32, as a pipelined divider.
// Depends on ado_pkg.
module ado_sdiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [31:0]    i_s,
    input  ado_pkg::t_side i_side,
    output logic           o_valid,
    output logic [32:0]    o_step,
    output ado_pkg::t_side o_side
);

    localparam int N = ado_pkg::SD_STAGES;

    logic           r_a_valid;
    logic [56:0]    r_a_den;
    ado_pkg::t_side r_a_side;

    logic [N:0]     r_valid;
    logic [56:0]    r_rem  [0:N];
    logic [33:0]    r_dvd  [0:N];
    logic [33:0]    r_quo  [0:N];
    logic [56:0]    r_den  [0:N];
    logic           r_ovf  [0:N];
    ado_pkg::t_side r_side [0:N];

    logic [56:0] n_rem [1:N];
    logic [33:0] n_dvd [1:N];
    logic [33:0] n_quo [1:N];

    always_comb begin : div_steps
        logic [57:0] t;
        logic [56:0] rem;
        logic [33:0] dvd;
        logic [33:0] quo;
        for (int s = 0; s < N; s++) begin
            rem = r_rem[s];
            dvd = r_dvd[s];
            quo = r_quo[s];
            for (int j = 0; j < ado_pkg::SD_STEPS; j++) begin
                t   = {rem, dvd[33]};
                dvd = {dvd[32:0], 1'b0};
                if (t >= {1'b0, r_den[s]}) begin
                    rem = 57'(t - {1'b0, r_den[s]});
                    quo = {quo[32:0], 1'b1};
                end else begin
                    rem = t[56:0];
                    quo = {quo[32:0], 1'b0};
                end
            end
            n_rem[s+1] = rem;
            n_dvd[s+1] = dvd;
            n_quo[s+1] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= '0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_valid   <= {r_valid[N-1:0], r_a_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_den  <= i_side.q1 * i_s;
            r_a_side <= i_side;
            // quotient of 2^33 or more is saturated
            r_ovf[0]  <= (57'(r_a_side.num[55:13]) >= r_a_den);
            r_rem[0]  <= 57'(r_a_side.num[55:14]);
            r_dvd[0]  <= {r_a_side.num[13:0], 20'd0};
            r_quo[0]  <= '0;
            r_den[0]  <= r_a_den;
            r_side[0] <= r_a_side;
            for (int s = 0; s < N; s++) begin
                r_rem[s+1]  <= n_rem[s+1];
                r_dvd[s+1]  <= n_dvd[s+1];
                r_quo[s+1]  <= n_quo[s+1];
                r_den[s+1]  <= r_den[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_step  = (r_ovf[N] || r_quo[N] > 34'(ado_pkg::STEP_MAX)) ? ado_pkg::STEP_MAX
                     : r_quo[N][32:0];
    assign o_valid = r_valid[N];
    assign o_side  = r_side[N];

endmodule

[rtl/adam_optimizer_update_unit.sv]
// Adam weight update unit. Takes one item per clock while input is not stalled
// and returns one result per item, in order. A begin-step item advances the
// decay powers; an element item reads and rewrites its two moments in the
// moment memories (one read and one write port each, with the last write
// forwarded), which set the rate of one element per cycle, then passes through
// pipelined divide, square root and divide units. A skid register behind the
// output register lets the pipeline run on while the receiver stalls; outside
// the clearing pass, input is stalled only while that skid register is full.
// After reset the moment memories are cleared in a pass during which input
// is stalled. Write configuration only while no item is in flight.
// Depends on ado_pkg and all ado_ modules.
module adam_optimizer_update_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [11:0]                       i_element_index,
    input  logic signed [31:0]                i_weight_in,
    input  logic signed [31:0]                i_gradient,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_weight_out,
    output logic                              o_status,
    input  logic                              i_cfg_we,
    input  logic [ado_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ado_pkg::CFG_W-1:0]         i_cfg_data
);

    ado_pkg::t_cfg r_cfg;
    logic          w_en, w_acc, w_clearing;

    logic           w_mu_valid, w_vd_valid, w_sq_valid, w_sd_valid;
    logic [47:0]    w_mu_v;
    logic [24:0]    w_mu_q2;
    logic [63:0]    w_vd_x;
    logic [31:0]    w_sq_s;
    logic [32:0]    w_sd_step;
    ado_pkg::t_side w_mu_side, w_vd_side, w_sq_side, w_sd_side;

    logic               r_out_valid, r_status;
    logic signed [31:0] r_weight;
    logic               r_skid_valid, r_skid_status;
    logic signed [31:0] r_skid_weight;
    logic               w_out_free;

    // whole pipeline advances unless the skid register holds a result
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid || w_clearing;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lr       <= ado_pkg::RST_LEARNING_RATE;
            r_cfg.d2       <= ado_pkg::RST_DECAY_SECOND;
            r_cfg.d1       <= ado_pkg::RST_DECAY_FIRST;
            r_cfg.mode     <= ado_pkg::MODE_NONE;
            r_cfg.strength <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ado_pkg::CFG_LEARNING_RATE: r_cfg.lr       <= i_cfg_data;
                ado_pkg::CFG_DECAY_SECOND:  r_cfg.d2       <= i_cfg_data;
                ado_pkg::CFG_DECAY_FIRST:   r_cfg.d1       <= i_cfg_data;
                ado_pkg::CFG_REG_MODE:      r_cfg.mode     <= i_cfg_data[1:0];
                ado_pkg::CFG_REG_STRENGTH:  r_cfg.strength <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ado_moment_unit u_moment (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_acc      (w_acc),
        .i_cfg      (r_cfg),
        .i_kind     (i_kind),
        .i_idx      (i_element_index),
        .i_w        (i_weight_in),
        .i_g        (i_gradient),
        .o_clearing (w_clearing),
        .o_valid    (w_mu_valid),
        .o_v        (w_mu_v),
        .o_q2       (w_mu_q2),
        .o_side     (w_mu_side)
    );

    ado_vdiv u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mu_valid),
        .i_v     (w_mu_v),
        .i_q2    (w_mu_q2),
        .i_side  (w_mu_side),
        .o_valid (w_vd_valid),
        .o_x     (w_vd_x),
        .o_side  (w_vd_side)
    );

    ado_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vd_valid),
        .i_x     (w_vd_x),
        .i_side  (w_vd_side),
        .o_valid (w_sq_valid),
        .o_s     (w_sq_s),
        .o_side  (w_sq_side)
    );

    ado_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_s     (w_sq_s),
        .i_side  (w_sq_side),
        .o_valid (w_sd_valid),
        .o_step  (w_sd_step),
        .o_side  (w_sd_side)
    );

    logic signed [34:0] w_w35, w_step35, w_wsum;
    logic signed [31:0] w_weight;

    assign w_w35    = 35'(signed'(w_sd_side.w));
    assign w_step35 = signed'({2'b00, w_sd_step});
    // step carries the sign of m: subtract for positive m
    assign w_wsum   = w_sd_side.neg ? (w_w35 + w_step35) : (w_w35 - w_step35);
    assign w_weight = w_sd_side.upd ? ado_pkg::sat32(64'(w_wsum)) : signed'(w_sd_side.w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            if (w_out_free) begin
                r_out_valid <= w_sd_valid;
            end else if (w_sd_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (!i_out_stall) begin
            // drain the skid register into the output register
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_out_free) begin
                r_weight <= w_weight;
                r_status <= w_sd_side.status;
            end else begin
                r_skid_weight <= w_weight;
                r_skid_status <= w_sd_side.status;
            end
        end else if (!i_out_stall) begin
            r_weight <= r_skid_weight;
            r_status <= r_skid_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight_out = r_weight;
    assign o_status     = r_status;

endmodule

[test/adam_optimizer_update_unit_tb.sv]
// Self-checking testbench for the Adam update unit: a local fixed-point predictor
// feeds an in-order queue of expected weights. Depends on ado_pkg and the RTL.
module adam_optimizer_update_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q = 64'sd16777216;
    localparam int     IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] weight;
        logic               status;
    } t_weight_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_kind = ado_pkg::KIND_STEP;
    logic [11:0]                         i_element_index = '0;
    logic signed [31:0]                  i_weight_in = '0;
    logic signed [31:0]                  i_gradient = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [31:0]                  o_weight_out;
    logic                                o_status;
    logic                                i_cfg_we = 1'b0;
    logic [ado_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [ado_pkg::CFG_W-1:0]           i_cfg_data = '0;

    adam_optimizer_update_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state and register copies
    logic [23:0]        lr_q, d2_q, d1_q, strength_q;
    logic [1:0]         mode_q;
    int                 moment_m [ado_pkg::NUM_ELEMENTS];
    longint unsigned    moment_v [ado_pkg::NUM_ELEMENTS];
    longint unsigned    pow_first, pow_second;

    t_weight_result     expected_weights[$];
    int                 errors = 0;
    int                 n_items = 0, n_results = 0, n_steps = 0, n_rejected = 0;

    // Sender and receiver idling controls
    bit                 gaps_on = 1'b1;
    int                 stall_pct = 30;
    int                 burst_left = 0;
    int                 holdoff_req = 0, holdoff_seen = 0, holdoff_cnt = 0;

    function automatic longint clamp_q824(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned bias_denominator(input longint unsigned p);
        longint unsigned q;
        q = (p >= ONE_Q) ? 0 : ONE_Q - p;
        return (q != 0) ? q : 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] update_weight(input int idx, input longint w,
                                                         input longint g_in);
        longint          g, m;
        longint unsigned mag, gsq, v, hi, lo, vh, qa, ra, x, s, q1, q2, num, den, step;
        g = g_in;
        if (mode_q == ado_pkg::MODE_L2)
            g = clamp_q824(g + ((2 * longint'(strength_q) * w) >>> 24));
        m = (longint'(d1_q) * moment_m[idx] + (ONE_Q - longint'(d1_q)) * g) >>> 24;
        m = clamp_q824(m);
        moment_m[idx] = int'(m);

        mag = (g < 0) ? -g : g;
        gsq = (mag * mag) >> 16;
        v = moment_v[idx];
        hi = longint'(d2_q) * (v >> 24) + (ONE_Q - longint'(d2_q)) * (gsq >> 24);
        lo = longint'(d2_q) * (v & 64'hFFFFFF)
             + (ONE_Q - longint'(d2_q)) * (gsq & 64'hFFFFFF);
        v = hi + (lo >> 24);
        if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
        moment_v[idx] = v;

        q2 = bias_denominator(pow_second);
        qa = v / q2;
        ra = v % q2;
        if (qa >= (64'd1 << 32)) vh = '1;
        else vh = (qa << 32) + (ra << 32) / q2;
        x = (vh > 64'hFFFF_FFFF_FFFF_FFFF - 10995) ? '1 : vh + 10995;
        s = int_sqrt(x);

        q1 = bias_denominator(pow_first);
        num = longint'(lr_q) * ((m < 0) ? -m : m);
        den = q1 * s;
        qa = num / den;
        ra = num % den;
        if (qa >= (64'd1 << 32)) begin
            step = 64'd1 << 32;
        end else begin
            step = qa;
            for (int i = 0; i < 20; i++) begin
                ra <<= 1;
                step <<= 1;
                if (ra >= den) begin
                    ra -= den;
                    step |= 1;
                end
            end
            if (step > (64'd1 << 32)) step = 64'd1 << 32;
        end
        return 32'(clamp_q824((m < 0) ? w + longint'(step) : w - longint'(step)));
    endfunction

    function automatic t_weight_result predict_item(input logic kind, input logic [11:0] idx,
                                                    input logic signed [31:0] w,
                                                    input logic signed [31:0] g);
        t_weight_result r;
        r.weight = w;
        r.status = 1'b0;
        if (kind == ado_pkg::KIND_STEP) begin
            pow_first  = (pow_first * d1_q) >> 24;
            pow_second = (pow_second * d2_q) >> 24;
            n_steps++;
        end else if (mode_q == ado_pkg::MODE_L1 || mode_q == ado_pkg::MODE_UNK) begin
            r.status = 1'b1;
            n_rejected++;
        end else if (int'(idx) < ado_pkg::NUM_ELEMENTS) begin
            r.weight = update_weight(int'(idx), longint'(w), longint'(g));
        end
        return r;
    endfunction

    task automatic reset_model();
        lr_q = ado_pkg::RST_LEARNING_RATE;
        d2_q = ado_pkg::RST_DECAY_SECOND;
        d1_q = ado_pkg::RST_DECAY_FIRST;
        mode_q = ado_pkg::MODE_NONE;
        strength_q = '0;
        pow_first = ONE_Q;
        pow_second = ONE_Q;
        foreach (moment_m[i]) begin
            moment_m[i] = 0;
            moment_v[i] = 0;
        end
    endtask

    // Called at a clock edge, with the block idle
    task automatic write_reg(input logic [ado_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ado_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ado_pkg::CFG_LEARNING_RATE: lr_q = data;
            ado_pkg::CFG_DECAY_SECOND:  d2_q = data;
            ado_pkg::CFG_DECAY_FIRST:   d1_q = data;
            ado_pkg::CFG_REG_MODE:      mode_q = data[1:0];
            ado_pkg::CFG_REG_STRENGTH:  strength_q = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        write_reg(ado_pkg::CFG_REG_MODE, {22'd0, mode});
    endtask

    task automatic drain();
        while (expected_weights.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic send_item(input logic kind, input logic [11:0] idx,
                             input logic signed [31:0] w, input logic signed [31:0] g);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_element_index <= idx;
        i_weight_in <= w;
        i_gradient <= g;
        do @(posedge i_clk); while (o_in_stall);
        expected_weights.push_back(predict_item(kind, idx, w, g));
        n_items++;
    endtask

    task automatic end_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return 0;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // Mostly a small working set so moments are reused, often back to back
    function automatic logic [11:0] pick_index();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, ado_pkg::NUM_ELEMENTS - 1));
        return 12'($urandom_range(0, 15));
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(ado_pkg::KIND_STEP, 12'($urandom), $urandom, $urandom);
            else
                send_item(ado_pkg::KIND_ELEM, pick_index(), pick_value(), pick_value());
        end
        end_sending();
    endtask

    task automatic test_directed();
        // No step begun yet: largest bias correction
        send_item(ado_pkg::KIND_ELEM, 12'd0, 32'sh0100_0000, 32'sh0010_0000);
        send_item(ado_pkg::KIND_ELEM, 12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(ado_pkg::KIND_ELEM, 12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(ado_pkg::KIND_STEP, 12'd0, 32'sh1234_5678, 32'sh0);
        send_item(ado_pkg::KIND_ELEM, 12'd0, 32'sh0, 32'sh0);
        send_item(ado_pkg::KIND_ELEM, 12'd0, 32'sh0, 32'sh8000_0000);
        send_item(ado_pkg::KIND_STEP, 12'hFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(ado_pkg::KIND_ELEM, 12'd1, -32'sd1, -32'sd1);
        send_item(ado_pkg::KIND_ELEM, 12'd1, 32'sd1, 32'sd1);
        end_sending();
        drain();
        // Rejected modes; a begin-step item is sent too but is not rejected
        write_mode(ado_pkg::MODE_L1);
        send_item(ado_pkg::KIND_ELEM, 12'd2, 32'sh0100_0000, 32'sh0100_0000);
        send_item(ado_pkg::KIND_STEP, 12'd2, 32'sh0100_0000, 32'sh0100_0000);
        end_sending();
        drain();
        write_mode(ado_pkg::MODE_UNK);
        send_item(ado_pkg::KIND_ELEM, 12'd2, 32'sh8000_0000, 32'sh7FFF_FFFF);
        end_sending();
        drain();
        // L2 at full strength on extreme weights
        write_mode(ado_pkg::MODE_L2);
        write_reg(ado_pkg::CFG_REG_STRENGTH, 24'hFFFFFF);
        send_item(ado_pkg::KIND_ELEM, 12'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(ado_pkg::KIND_ELEM, 12'd3, 32'sh8000_0000, 32'sh8000_0000);
        send_item(ado_pkg::KIND_ELEM, 12'd4, 32'sh0100_0000, 32'sh0);
        end_sending();
        drain();
    endtask

    task automatic test_settings();
        logic [ado_pkg::CFG_W-1:0] lr_set [4] = '{24'hFFFFFF, 24'd0,
                                                  ado_pkg::RST_LEARNING_RATE, 24'h123456};
        logic [ado_pkg::CFG_W-1:0] d_set  [4] = '{24'd0, 24'hFFFFFF, 24'h800000,
                                                  ado_pkg::RST_DECAY_FIRST};
        for (int p = 0; p < 4; p++) begin
            write_reg(ado_pkg::CFG_LEARNING_RATE, lr_set[p]);
            write_reg(ado_pkg::CFG_DECAY_FIRST, d_set[p]);
            write_reg(ado_pkg::CFG_DECAY_SECOND, d_set[3 - p]);
            write_mode((p == 2) ? ado_pkg::MODE_L2 : ado_pkg::MODE_NONE);
            write_reg(ado_pkg::CFG_REG_STRENGTH, 24'($urandom));
            stall_pct = (p == 1) ? 0 : 35;
            gaps_on = (p != 1);
            random_items(240);
            drain();
        end
        write_mode($urandom_range(0, 1) ? ado_pkg::MODE_L1 : ado_pkg::MODE_UNK);
        random_items(60);
        drain();
    endtask

    task automatic test_backpressure();
        write_mode(ado_pkg::MODE_NONE);
        write_reg(ado_pkg::CFG_LEARNING_RATE, ado_pkg::RST_LEARNING_RATE);
        write_reg(ado_pkg::CFG_DECAY_FIRST, ado_pkg::RST_DECAY_FIRST);
        write_reg(ado_pkg::CFG_DECAY_SECOND, ado_pkg::RST_DECAY_SECOND);
        gaps_on = 1'b0;
        holdoff_req++;
        random_items(250);
        gaps_on = 1'b1;
        stall_pct = 50;
        random_items(200);
        drain();
        // Sender pauses for a full drain mid-stream
        random_items(150);
        drain();
        stall_pct = 20;
        random_items(130);
        drain();
    endtask

    // Receiver stall pattern, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            holdoff_cnt = 400;
        end
        if (holdoff_cnt > 0) begin
            holdoff_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_weight_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_weights.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = expected_weights.pop_front();
                if (o_weight_out !== exp_r.weight) begin
                    $error("weight_out mismatch: expected %0d got %0d",
                           exp_r.weight, o_weight_out);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status mismatch: expected %0d got %0d", exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_settings();
        test_backpressure();
        drain();
        $display("Run covered %0d items (%0d begin-step, %0d rejected), %0d results checked,",
                 n_items, n_steps, n_rejected, n_results);
        $display("over decay, rate and regularisation settings with idling and long stalls.");
        if (errors == 0 && expected_weights.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
